### hdl/fru_pkg.sv
`timescale 1ns / 1ps

package fru_pkg;

  localparam int WINDOW_LEN = 32;
  localparam int IDX_W      = $clog2(WINDOW_LEN);
  localparam int TS_W       = 32;
  localparam int TPS_W      = 20;
  localparam int RATE_W     = 16;
  localparam int SUM_W      = TS_W + IDX_W;
  localparam int NUM_W      = TPS_W + IDX_W;
  localparam int CNT_W      = $clog2(NUM_W + 1);

  localparam logic [TPS_W-1:0]  TPS_RESET = TPS_W'(1000);
  localparam logic [RATE_W-1:0] RATE_MAX  = '1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/fru_ring.sv
`timescale 1ns / 1ps

module fru_ring (
  input  logic                     clk,
  input  logic                     we,
  input  logic [fru_pkg::IDX_W-1:0] waddr,
  input  logic [fru_pkg::TS_W-1:0]  wdata,
  input  logic [fru_pkg::IDX_W-1:0] raddr,
  output logic [fru_pkg::TS_W-1:0]  rdata
);

  logic [fru_pkg::TS_W-1:0] mem [fru_pkg::WINDOW_LEN];
  logic [fru_pkg::TS_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/fru_div.sv
`timescale 1ns / 1ps

module fru_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fru_pkg::NUM_W-1:0]  num,
  input  logic [fru_pkg::SUM_W-1:0]  den,
  output fru_pkg::div_stat_t         stat,
  output logic [fru_pkg::NUM_W-1:0]  quo
);

  localparam int PAD_W = fru_pkg::SUM_W - fru_pkg::NUM_W;

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [fru_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [fru_pkg::NUM_W-1:0] rem_r, rem_nxt;
  logic [fru_pkg::NUM_W-1:0] quo_r, quo_nxt;
  logic [fru_pkg::NUM_W-1:0] num_r, num_nxt;
  logic [fru_pkg::SUM_W-1:0] den_r, den_nxt;
  logic [fru_pkg::NUM_W:0]   trial;
  logic [fru_pkg::SUM_W:0]   diff;
  logic                      fits;

  // one restoring step per cycle
  assign trial = {rem_r, num_r[fru_pkg::NUM_W-1]};
  assign diff  = {{PAD_W{1'b0}}, trial} - {1'b0, den_r};
  assign fits  = ~diff[fru_pkg::SUM_W];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = fru_pkg::CNT_W'(fru_pkg::NUM_W);
      rem_nxt  = '0;
      quo_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[fru_pkg::NUM_W-1:0] : trial[fru_pkg::NUM_W-1:0];
      quo_nxt = {quo_r[fru_pkg::NUM_W-2:0], fits};
      num_nxt = {num_r[fru_pkg::NUM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == fru_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

`ifndef NO_ASSERTIONS
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r)) else $error("divider busy and done together");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a run");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("divider did not start");
`endif

endmodule

### hdl/sliding_window_frame_rate_unit.sv
`timescale 1ns / 1ps
// flow: an accepted word passes the SUM, CHK and FIN states during warm-up or on a zero window,
// and the SUM, CHK, DIV and FIN states when a rate is computed
// input: a new word is taken only in IDLE, once the bit-serial restoring divider and the last result are done
// reset: synchronous active low; clears the sequencer, window sum, fill state,
// last timestamp and held rate, and sets ticks per second to 1000

module sliding_window_frame_rate_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fru_pkg::TS_W-1:0]     in_timestamp,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fru_pkg::RATE_W-1:0]   out_frame_rate,
  output logic                         out_rate_ready,
  output logic                         out_zero_window,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fru_pkg::TPS_W-1:0]    cfg_ticks_per_second
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_CHK  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [fru_pkg::TPS_W-1:0]   tps_r;
  logic [fru_pkg::TS_W-1:0]    last_r;
  logic [fru_pkg::TS_W-1:0]    delta_r;
  logic [fru_pkg::IDX_W-1:0]   ptr_r;
  logic                        full_r;
  logic                        calc_r;
  logic [fru_pkg::SUM_W-1:0]   sum_r;
  logic [fru_pkg::RATE_W-1:0]  rate_hold_r;
  logic                        res_ready_r;
  logic                        res_zero_r;
  logic                        out_valid_r;
  logic [fru_pkg::RATE_W-1:0]  out_rate_r;
  logic                        out_rdy_r;
  logic                        out_zero_r;

  logic [fru_pkg::TS_W-1:0]    old_delta;
  logic [fru_pkg::SUM_W-1:0]   sum_nxt;
  logic                        ring_we;
  logic                        div_start;
  logic [fru_pkg::NUM_W-1:0]   div_num;
  logic [fru_pkg::NUM_W-1:0]   div_quo;
  fru_pkg::div_stat_t          div_stat;
  logic [fru_pkg::RATE_W-1:0]  rate_sat;
  logic                        in_acc;
  logic                        out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign ring_we   = (state_r == ST_SUM);
  assign div_start = (state_r == ST_CHK) && calc_r && (sum_r != '0);
  assign div_num   = fru_pkg::NUM_W'(tps_r) * fru_pkg::NUM_W'(fru_pkg::WINDOW_LEN);
  assign rate_sat  = (|div_quo[fru_pkg::NUM_W-1:fru_pkg::RATE_W]) ? fru_pkg::RATE_MAX
                                                                  : div_quo[fru_pkg::RATE_W-1:0];
  assign sum_nxt   = full_r ? (sum_r - fru_pkg::SUM_W'(old_delta) + fru_pkg::SUM_W'(delta_r))
                            : (sum_r + fru_pkg::SUM_W'(delta_r));

  fru_ring u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ptr_r),
    .wdata (delta_r),
    .raddr (ptr_r),
    .rdata (old_delta)
  );

  fru_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (sum_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_CHK;
      ST_CHK:  state_nxt = div_start ? ST_DIV : ST_FIN;
      ST_DIV:  if (div_stat.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tps_r       <= fru_pkg::TPS_RESET;
      last_r      <= '0;
      ptr_r       <= '0;
      full_r      <= 1'b0;
      calc_r      <= 1'b0;
      sum_r       <= '0;
      rate_hold_r <= '0;
      res_ready_r <= 1'b0;
      res_zero_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        tps_r <= cfg_ticks_per_second;
      end
      if (in_acc) begin
        last_r <= in_timestamp;
      end
      if (state_r == ST_SUM) begin
        sum_r  <= sum_nxt;
        calc_r <= full_r;
        if (ptr_r == fru_pkg::IDX_W'(fru_pkg::WINDOW_LEN - 1)) begin
          ptr_r  <= '0;
          full_r <= 1'b1;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      if (state_r == ST_CHK) begin
        res_ready_r <= 1'b0;
        res_zero_r  <= calc_r && (sum_r == '0);
      end
      if ((state_r == ST_DIV) && div_stat.done) begin
        rate_hold_r <= rate_sat;
        res_ready_r <= 1'b1;
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      delta_r <= in_timestamp - last_r;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_rate_r <= rate_hold_r;
      out_rdy_r  <= res_ready_r;
      out_zero_r <= res_zero_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_rate  = out_rate_r;
  assign out_rate_ready  = out_rdy_r;
  assign out_zero_window = out_zero_r;

`ifndef NO_ASSERTIONS
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rdy_r && out_zero_r)) else $error("ready and zero flags together");
  a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done)) else $error("divider idle in div");
  a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SUM) && (ptr_r == fru_pkg::IDX_W'(fru_pkg::WINDOW_LEN - 1))) |=> full_r)
    else $error("window not marked full after warm-up");
`endif

endmodule

### tb/sv/tb_sliding_window_frame_rate_unit.sv
`timescale 1ns / 1ps

module tb_sliding_window_frame_rate_unit;

  localparam int RUN_LIMIT    = 400000;
  localparam int SETTLE_TICKS = 40;
  localparam int HOLD_TICKS   = 300;
  localparam int PHASE_ITEMS  = 50;
  localparam int PHASES       = 6;

  typedef struct packed {
    logic [fru_pkg::RATE_W-1:0] frame_rate;
    logic                       rate_ready;
    logic                       zero_window;
  } rate_word_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [fru_pkg::TS_W-1:0] value;
    int                       reps;
    bit                       typed;
    rate_word_t               word;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic [fru_pkg::TS_W-1:0]   in_timestamp;
  logic                       out_valid;
  logic                       out_ready;
  logic [fru_pkg::RATE_W-1:0] out_frame_rate;
  logic                       out_rate_ready;
  logic                       out_zero_window;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [fru_pkg::TPS_W-1:0]  cfg_ticks_per_second;

  sliding_window_frame_rate_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_timestamp         (in_timestamp),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frame_rate       (out_frame_rate),
    .out_rate_ready       (out_rate_ready),
    .out_zero_window      (out_zero_window),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_ticks_per_second (cfg_ticks_per_second)
  );

  // window state mirrored for prediction
  logic [fru_pkg::TS_W-1:0]   win_delta [fru_pkg::WINDOW_LEN];
  logic [fru_pkg::IDX_W-1:0]  win_oldest;
  int                         win_fill;
  logic [fru_pkg::SUM_W-1:0]  win_sum;
  logic [fru_pkg::TS_W-1:0]   win_last_ts;
  logic [fru_pkg::RATE_W-1:0] held_rate;
  logic [fru_pkg::TPS_W-1:0]  tps_reg;

  rate_word_t        rate_q [$];
  rate_word_t        want_word;
  rate_word_t        calc_word;
  logic              typed_flag;
  rate_word_t        typed_word;

  int                         errors = 0;
  int                         cycle_count = 0;
  int                         in_idle_pct;
  int                         out_idle_pct;
  bit                         hold_req;
  logic [fru_pkg::TS_W-1:0]   ts_now;
  logic [fru_pkg::TPS_W-1:0]  phase_tps [PHASES];
  int                         row_i;
  int                         rep_i;
  int                         phase_i;
  int                         item_i;

  stim_row_t dir_rows [15] = '{
    '{ROW_TICK, 32'hFFFF_FFFF, 1,  1'b1, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'd1,         1,  1'b1, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'd0,         30, 1'b1, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'd0,         1,  1'b1, '{16'd32000, 1'b1, 1'b0}},
    '{ROW_TICK, 32'd0,         3,  1'b1, '{16'd32000, 1'b0, 1'b1}},
    '{ROW_CFG,  32'hF_FFFF,    1,  1'b0, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'd1,         1,  1'b1, '{16'hFFFF,  1'b1, 1'b0}},
    '{ROW_CFG,  32'd0,         1,  1'b0, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'd0,         1,  1'b1, '{16'd0,     1'b1, 1'b0}},
    '{ROW_CFG,  32'd1,         1,  1'b0, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'hFFFF_FFFF, 1,  1'b1, '{16'd0,     1'b1, 1'b0}},
    '{ROW_CFG,  32'd1000000,   1,  1'b0, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'hFFFF_FFFF, 31, 1'b0, '{16'd0,     1'b0, 1'b0}},
    '{ROW_TICK, 32'd12345,     4,  1'b0, '{16'd0,     1'b0, 1'b0}},
    '{ROW_CFG,  32'd1000,      1,  1'b0, '{16'd0,     1'b0, 1'b0}}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic rate_word_t next_rate(logic [fru_pkg::TS_W-1:0] ts);
    logic [fru_pkg::TS_W-1:0]  delta;
    logic [fru_pkg::NUM_W-1:0] num;
    logic [63:0]               quot;
    rate_word_t                res;
    delta = ts - win_last_ts;
    win_last_ts = ts;
    res = '0;
    if (win_fill < fru_pkg::WINDOW_LEN) begin
      win_delta[win_fill] = delta;
      win_sum = win_sum + delta;
      win_fill++;
    end else begin
      win_sum = win_sum - win_delta[win_oldest] + delta;
      win_delta[win_oldest] = delta;
      win_oldest = (win_oldest == fru_pkg::IDX_W'(fru_pkg::WINDOW_LEN - 1)) ? '0
                                                                          : win_oldest + 1'b1;
      if (win_sum == '0) begin
        res.zero_window = 1'b1;
      end else begin
        num = fru_pkg::NUM_W'(tps_reg) * fru_pkg::NUM_W'(fru_pkg::WINDOW_LEN);
        quot = 64'(num) / 64'(win_sum);
        held_rate = (quot > 64'(fru_pkg::RATE_MAX)) ? fru_pkg::RATE_MAX
                                                    : quot[fru_pkg::RATE_W-1:0];
        res.rate_ready = 1'b1;
      end
    end
    res.frame_rate = held_rate;
    return res;
  endfunction

  function automatic logic [fru_pkg::TS_W-1:0] next_timestamp(logic [fru_pkg::TS_W-1:0] prev,
                                                              logic [fru_pkg::TPS_W-1:0] tps);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45)
      return prev + tps / $urandom_range(240, 24) + $urandom_range(3);
    else if (pick < 60)
      return prev + $urandom_range(3);
    else if (pick < 70)
      return $urandom;
    else if (pick < 78)
      return prev - $urandom_range(4, 1);
    else
      return prev + $urandom_range(65535);
  endfunction

  task automatic compare_field(string field, logic [fru_pkg::RATE_W-1:0] want,
                               logic [fru_pkg::RATE_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endtask

  // result check first: a word leaving cannot belong to one entering at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rate_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word expected none got rate %0d ready %0b zero %0b",
                   $time, out_frame_rate, out_rate_ready, out_zero_window);
        end else begin
          want_word = rate_q.pop_front();
          compare_field("frame_rate", want_word.frame_rate, out_frame_rate);
          compare_field("rate_ready", fru_pkg::RATE_W'(want_word.rate_ready),
                        fru_pkg::RATE_W'(out_rate_ready));
          compare_field("zero_window", fru_pkg::RATE_W'(want_word.zero_window),
                        fru_pkg::RATE_W'(out_zero_window));
        end
      end
      if (cfg_valid && cfg_ready)
        tps_reg = cfg_ticks_per_second;
      if (in_valid && in_ready) begin
        calc_word = next_rate(in_timestamp);
        rate_q.push_back(typed_flag ? typed_word : calc_word);
      end
    end
  end

  // receiver with random stalls and one long hold-off
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (HOLD_TICKS) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_tick(logic [fru_pkg::TS_W-1:0] ts, bit typed, rate_word_t word);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_timestamp <= ts;
    typed_flag   <= typed;
    typed_word   <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rate_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_tps(logic [fru_pkg::TPS_W-1:0] value);
    drain_results();
    cfg_valid            <= 1'b1;
    cfg_ticks_per_second <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_valid             <= 1'b0;
    in_timestamp         <= '0;
    typed_flag           <= 1'b0;
    typed_word           <= '0;
    cfg_valid            <= 1'b0;
    cfg_ticks_per_second <= '0;
    out_ready            <= 1'b0;
    hold_req     = 1'b0;
    in_idle_pct  = 15;
    out_idle_pct = 15;
    win_oldest   = '0;
    win_fill     = 0;
    win_sum      = '0;
    win_last_ts  = '0;
    held_rate    = '0;
    tps_reg      = fru_pkg::TPS_RESET;
    ts_now       = '0;
    phase_tps[0] = 20'd60;
    phase_tps[1] = 20'd1000000;
    phase_tps[2] = 20'hF_FFFF;
    phase_tps[3] = 20'd1;
    phase_tps[4] = 20'd0;
    phase_tps[5] = fru_pkg::TPS_W'($urandom_range(1000000, 1));
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (row_i = 0; row_i < 15; row_i++) begin
      if (dir_rows[row_i].kind == ROW_CFG) begin
        write_tps(dir_rows[row_i].value[fru_pkg::TPS_W-1:0]);
      end else begin
        for (rep_i = 0; rep_i < dir_rows[row_i].reps; rep_i++) begin
          ts_now = ts_now + dir_rows[row_i].value;
          send_tick(ts_now, dir_rows[row_i].typed, dir_rows[row_i].word);
        end
      end
    end

    for (phase_i = 0; phase_i < PHASES; phase_i++) begin
      write_tps(phase_tps[phase_i]);
      in_idle_pct  = (phase_i == 1) ? 0 : 15;
      out_idle_pct = (phase_i == 1) ? 0 : 15;
      if (phase_i == 2)
        hold_req = 1'b1;
      // run of equal timestamps empties the window
      if (phase_i == 4) begin
        repeat (fru_pkg::WINDOW_LEN + 3) send_tick(ts_now, 1'b0, '0);
      end
      for (item_i = 0; item_i < PHASE_ITEMS; item_i++) begin
        if (phase_i == 3 && item_i == PHASE_ITEMS / 2)
          drain_results();
        ts_now = next_timestamp(ts_now, phase_tps[phase_i]);
        send_tick(ts_now, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
